// ----- rtl/huffman_tree_decoder_unit_macros.svh -----
// Assertion macros for the Huffman tree decoder checker.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef HUFFMAN_TREE_DECODER_UNIT_MACROS_SVH
`define HUFFMAN_TREE_DECODER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define HTD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/htd_pkg.sv -----
// Shared types and constants of the Huffman tree decoder.
// No dependencies; used by every module of the block but the checker.
package htd_pkg;

    localparam int NODE_COUNT_DEF = 511;
    localparam int IDX_W          = 9;
    localparam int SYM_W          = 8;
    localparam int CNT_W          = 32;
    localparam int BITS_PER_BYTE  = 8;
    localparam int BIT_CNT_W      = 4;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    // Sequencer states
    typedef enum logic [5:0] {
        ST_CLEAR     = 6'b000001,
        ST_IDLE      = 6'b000010,
        ST_DECODE    = 6'b000100,
        ST_FLUSH     = 6'b001000,
        ST_LOAD_READ = 6'b010000,
        ST_LOAD_LINK = 6'b100000
    } state_t;

    // One tree node as read from the node store
    typedef struct packed {
        logic             has_left;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic [SYM_W-1:0] sym;
    } node_info_t;

    // Write control for the node store: per-field enables, shared data
    typedef struct packed {
        logic             en_has_left;
        logic             en_left;
        logic             en_right;
        logic             en_sym;
        logic             has_left;
        logic [IDX_W-1:0] link;
        logic [SYM_W-1:0] sym;
    } wr_ctl_t;

    // Status of the decoded-symbol counter
    typedef struct packed {
        logic done;   // count >= total
        logic near;   // count + 1 >= total
    } cnt_flags_t;

endpackage

// ----- rtl/huffman_tree_decoder_unit.sv -----
// Top level of the Huffman tree decoder: sequencer, output register, config.
// Depends on htd_pkg, htd_node_store and htd_count_unit.
//
//   channel | signals                                          | dir
//   --------+--------------------------------------------------+-----
//   in      | in_valid in_ready req_type node_index            | in
//           | parent_index node_symbol code_byte               |
//   out     | out_valid out_ready symbol last done_res         | out
//   cfg     | cfg_valid cfg_ready cfg_data (total_symbols)     | in
//
// A code byte walks one code bit per cycle through the shared node read port
// while the output is free, and stops early once total_symbols is reached;
// ready returns only once the byte has been flushed.
// A node load writes the node, then does a read-modify-write of the parent; a
// root (out-of-range parent) or an out-of-range node goes straight back to idle.
// After reset a clearing pass over every node zeroes has_left; no item is
// taken meanwhile, cfg writes are. A stalled output holds the sequencer.
module huffman_tree_decoder_unit #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      req_type,
    input  logic [htd_pkg::IDX_W-1:0] node_index,
    input  logic [htd_pkg::IDX_W-1:0] parent_index,
    input  logic [htd_pkg::SYM_W-1:0] node_symbol,
    input  logic [htd_pkg::SYM_W-1:0] code_byte,
    // output channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [htd_pkg::SYM_W-1:0] symbol,
    output logic                      last,
    output logic                      done_res,
    // configuration channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [htd_pkg::CNT_W-1:0] cfg_data
);

    localparam int AW = $clog2(NODE_COUNT);

    htd_pkg::state_t state_reg;
    htd_pkg::state_t state_next;

    logic [AW-1:0]                 clr_idx_reg;
    logic [AW-1:0]                 clr_idx_next;
    logic [htd_pkg::CNT_W-1:0]     total_reg;
    logic [htd_pkg::CNT_W-1:0]     total_next;
    logic [htd_pkg::SYM_W-1:0]     bits_reg;
    logic [htd_pkg::SYM_W-1:0]     bits_next;
    logic [htd_pkg::BIT_CNT_W-1:0] bits_left_reg;
    logic [htd_pkg::BIT_CNT_W-1:0] bits_left_next;
    logic                          rd_pending_reg;
    logic                          rd_pending_next;
    logic                          at_root_reg;
    logic                          at_root_next;
    htd_pkg::node_info_t           cur_info_reg;
    htd_pkg::node_info_t           cur_info_next;
    logic [htd_pkg::IDX_W-1:0]     node_reg;
    logic [htd_pkg::IDX_W-1:0]     node_next;
    logic [htd_pkg::IDX_W-1:0]     parent_reg;
    logic [htd_pkg::IDX_W-1:0]     parent_next;

    logic                      hold_valid_reg;
    logic                      hold_valid_next;
    logic [htd_pkg::SYM_W-1:0] hold_sym_reg;
    logic [htd_pkg::SYM_W-1:0] hold_sym_next;
    logic                      hold_done_reg;
    logic                      hold_done_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [htd_pkg::SYM_W-1:0] out_sym_reg;
    logic                      out_last_reg;
    logic                      out_done_reg;

    htd_pkg::wr_ctl_t          wr;
    logic [htd_pkg::IDX_W-1:0] wr_addr;
    logic                      rd_en;
    logic [htd_pkg::IDX_W-1:0] rd_addr;
    htd_pkg::node_info_t       rd_info;
    htd_pkg::node_info_t       root_info;

    logic                cnt_clear;
    logic                cnt_inc;
    htd_pkg::cnt_flags_t flags;

    logic                      push;
    logic                      push_last;
    logic                      out_free;
    logic                      node_ok;
    logic                      parent_ok;
    logic                      res_emit;
    logic                      leaf_emit;
    logic                      done_eff;
    logic                      walk_root_eff;
    htd_pkg::node_info_t       cur_eff;
    logic                      start;
    logic [htd_pkg::IDX_W-1:0] step_addr;

    // Node store and counter
    htd_node_store #(
        .NODE_COUNT (NODE_COUNT)
    ) u_node_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_info   (rd_info),
        .root_info (root_info)
    );

    htd_count_unit u_count_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cnt_clear),
        .inc   (cnt_inc),
        .total (total_next),
        .flags (flags)
    );

    assign in_ready  = (state_reg == htd_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign node_ok   = (node_index < htd_pkg::IDX_W'(NODE_COUNT));
    assign parent_ok = (parent_index < htd_pkg::IDX_W'(NODE_COUNT));

    // Limit as it stands after this edge, so the flags follow a cfg write at once
    assign total_next = (cfg_valid && cfg_ready) ? cfg_data : total_reg;

    // Walk step: resolve the pending node read, then start the next bit
    always_comb
    begin
        res_emit      = rd_pending_reg && !rd_info.has_left;
        done_eff      = res_emit ? flags.near : flags.done;
        walk_root_eff = res_emit || (at_root_reg && !rd_pending_reg);
        if (walk_root_eff)
        begin
            cur_eff = root_info;
        end
        else if (rd_pending_reg)
        begin
            cur_eff = rd_info;
        end
        else
        begin
            cur_eff = cur_info_reg;
        end
        start     = (bits_left_reg != '0) && !done_eff;
        step_addr = bits_reg[htd_pkg::SYM_W-1] ? cur_eff.right : cur_eff.left;
        leaf_emit = start && !cur_eff.has_left;
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        bits_next       = bits_reg;
        bits_left_next  = bits_left_reg;
        rd_pending_next = rd_pending_reg;
        at_root_next    = at_root_reg;
        cur_info_next   = cur_info_reg;
        node_next       = node_reg;
        parent_next     = parent_reg;
        hold_valid_next = hold_valid_reg;
        hold_sym_next   = hold_sym_reg;
        hold_done_next  = hold_done_reg;
        wr              = '0;
        wr_addr         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        cnt_clear       = 1'b0;
        cnt_inc         = 1'b0;
        push            = 1'b0;
        push_last       = 1'b0;

        unique case (state_reg)
            htd_pkg::ST_CLEAR:
            begin
                wr.en_has_left = 1'b1;
                wr_addr        = htd_pkg::IDX_W'(clr_idx_reg);
                clr_idx_next   = clr_idx_reg + 1'b1;
                if (clr_idx_reg == AW'(NODE_COUNT - 1))
                begin
                    state_next = htd_pkg::ST_IDLE;
                end
            end

            htd_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == htd_pkg::REQ_DECODE)
                    begin
                        bits_next       = code_byte;
                        bits_left_next  = htd_pkg::BIT_CNT_W'(htd_pkg::BITS_PER_BYTE);
                        rd_pending_next = 1'b0;
                        state_next      = htd_pkg::ST_DECODE;
                    end
                    else if (node_ok)
                    begin
                        // fresh node: no children, walk and count restart
                        wr.en_has_left = 1'b1;
                        wr.en_left     = 1'b1;
                        wr.en_right    = 1'b1;
                        wr.en_sym      = 1'b1;
                        wr.sym         = node_symbol;
                        wr_addr        = node_index;
                        cnt_clear      = 1'b1;
                        at_root_next   = 1'b1;
                        node_next      = node_index;
                        parent_next    = parent_index;
                        if (parent_ok)
                        begin
                            state_next = htd_pkg::ST_LOAD_READ;
                        end
                    end
                end
            end

            htd_pkg::ST_LOAD_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = parent_reg;
                state_next = htd_pkg::ST_LOAD_LINK;
            end

            htd_pkg::ST_LOAD_LINK:
            begin
                // first child goes left, any later one overwrites right
                wr_addr = parent_reg;
                wr.link = node_reg;
                if (!rd_info.has_left)
                begin
                    wr.en_has_left = 1'b1;
                    wr.has_left    = 1'b1;
                    wr.en_left     = 1'b1;
                end
                else
                begin
                    wr.en_right = 1'b1;
                end
                state_next = htd_pkg::ST_IDLE;
            end

            htd_pkg::ST_DECODE:
            begin
                if (out_free)
                begin
                    if (rd_pending_reg)
                    begin
                        at_root_next = res_emit;
                        if (!res_emit)
                        begin
                            cur_info_next = rd_info;
                        end
                    end
                    rd_pending_next = 1'b0;
                    if (start)
                    begin
                        bits_next      = bits_reg << 1;
                        bits_left_next = bits_left_reg - 1'b1;
                        if (cur_eff.has_left)
                        begin
                            rd_en           = 1'b1;
                            rd_addr         = step_addr;
                            rd_pending_next = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = htd_pkg::ST_FLUSH;
                    end
                    // a new symbol pushes the held one out as not last
                    if (res_emit || leaf_emit)
                    begin
                        cnt_inc         = 1'b1;
                        push            = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_sym_next   = res_emit ? rd_info.sym : cur_eff.sym;
                        hold_done_next  = flags.near;
                    end
                end
            end

            htd_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    push            = hold_valid_reg;
                    push_last       = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = htd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = htd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        priority if (push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htd_pkg::ST_CLEAR;
            clr_idx_reg    <= '0;
            total_reg      <= '0;
            bits_left_reg  <= '0;
            rd_pending_reg <= 1'b0;
            at_root_reg    <= 1'b1;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            total_reg      <= total_next;
            bits_left_reg  <= bits_left_next;
            rd_pending_reg <= rd_pending_next;
            at_root_reg    <= at_root_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        bits_reg      <= bits_next;
        cur_info_reg  <= cur_info_next;
        node_reg      <= node_next;
        parent_reg    <= parent_next;
        hold_sym_reg  <= hold_sym_next;
        hold_done_reg <= hold_done_next;
        if (push)
        begin
            out_sym_reg  <= hold_sym_reg;
            out_last_reg <= push_last;
            out_done_reg <= hold_done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = out_sym_reg;
    assign last      = out_last_reg;
    assign done_res  = out_done_reg;

endmodule

// ----- rtl/htd_node_store.sv -----
// Node store: has_left, link and symbol memories plus a cached copy of the root.
// Depends on htd_pkg.
module htd_node_store #(
    parameter int NODE_COUNT = htd_pkg::NODE_COUNT_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  htd_pkg::wr_ctl_t         wr,
    input  logic [htd_pkg::IDX_W-1:0] wr_addr,
    input  logic                     rd_en,
    input  logic [htd_pkg::IDX_W-1:0] rd_addr,
    output htd_pkg::node_info_t      rd_info,
    output htd_pkg::node_info_t      root_info
);

    localparam int AW = $clog2(NODE_COUNT);

    logic                     has_left_mem [NODE_COUNT];
    logic [AW-1:0]            left_mem     [NODE_COUNT];
    logic [AW-1:0]            right_mem    [NODE_COUNT];
    logic [htd_pkg::SYM_W-1:0] sym_mem     [NODE_COUNT];

    logic                      rd_has_left_reg;
    logic [AW-1:0]             rd_left_reg;
    logic [AW-1:0]             rd_right_reg;
    logic [htd_pkg::SYM_W-1:0] rd_sym_reg;

    logic                       root_has_left_reg;
    logic [htd_pkg::IDX_W-1:0]  root_left_reg;
    logic [htd_pkg::IDX_W-1:0]  root_right_reg;
    logic [htd_pkg::SYM_W-1:0]  root_sym_reg;

    logic root_hit;

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (wr.en_has_left)
        begin
            has_left_mem[wr_addr[AW-1:0]] <= wr.has_left;
        end
        if (wr.en_left)
        begin
            left_mem[wr_addr[AW-1:0]] <= wr.link[AW-1:0];
        end
        if (wr.en_right)
        begin
            right_mem[wr_addr[AW-1:0]] <= wr.link[AW-1:0];
        end
        if (wr.en_sym)
        begin
            sym_mem[wr_addr[AW-1:0]] <= wr.sym;
        end
    end

    // Registered read port; data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_has_left_reg <= has_left_mem[rd_addr[AW-1:0]];
            rd_left_reg     <= left_mem[rd_addr[AW-1:0]];
            rd_right_reg    <= right_mem[rd_addr[AW-1:0]];
            rd_sym_reg      <= sym_mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_info.has_left = rd_has_left_reg;
    assign rd_info.left     = htd_pkg::IDX_W'(rd_left_reg);
    assign rd_info.right    = htd_pkg::IDX_W'(rd_right_reg);
    assign rd_info.sym      = rd_sym_reg;

    // Root cache follows every write to node 0
    assign root_hit = (wr_addr == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_has_left_reg <= 1'b0;
        end
        else if (root_hit && wr.en_has_left)
        begin
            root_has_left_reg <= wr.has_left;
        end
    end

    always_ff @(posedge clk)
    begin
        if (root_hit && wr.en_left)
        begin
            root_left_reg <= wr.link;
        end
        if (root_hit && wr.en_right)
        begin
            root_right_reg <= wr.link;
        end
        if (root_hit && wr.en_sym)
        begin
            root_sym_reg <= wr.sym;
        end
    end

    assign root_info.has_left = root_has_left_reg;
    assign root_info.left     = root_left_reg;
    assign root_info.right    = root_right_reg;
    assign root_info.sym      = root_sym_reg;

endmodule

// ----- rtl/htd_count_unit.sv -----
// Decoded-symbol counter with its compare unit against total_symbols.
// Depends on htd_pkg.
module htd_count_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      clear,
    input  logic                      inc,
    input  logic [htd_pkg::CNT_W-1:0] total,
    output htd_pkg::cnt_flags_t       flags
);

    logic [htd_pkg::CNT_W-1:0] count_reg;
    logic [htd_pkg::CNT_W-1:0] count_next;
    logic [htd_pkg::CNT_W:0]   ahead;
    logic                      done_reg;
    logic                      done_next;
    logic                      near_reg;
    logic                      near_next;

    // Next count, then both flags from it
    always_comb
    begin
        priority if (clear)
        begin
            count_next = '0;
        end
        else if (inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
        ahead     = {1'b0, count_next} + 1'b1;
        done_next = (count_next >= total);
        near_next = (ahead >= {1'b0, total});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b1;
            near_reg  <= 1'b1;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
            near_reg  <= near_next;
        end
    end

    assign flags.done = done_reg;
    assign flags.near = near_reg;

endmodule

// ----- rtl/htd_checker.sv -----
// Port-level checker for the Huffman tree decoder, bound to the top level.
// Depends on huffman_tree_decoder_unit_macros.svh.
`include "huffman_tree_decoder_unit_macros.svh"

module htd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       req_type,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] symbol,
    input logic       last,
    input logic       done_res
);

    // A stalled result holds its payload
    `HTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(symbol) && $stable(last) && $stable(done_res), "stalled result changed")

    // The symbol that completes the count ends its code byte
    `HTD_ASSERT_IMPL(a_done_is_last, out_valid && done_res, last, "done result not marked last")

    // While idle, a waiting result must be the final one of its byte
    `HTD_ASSERT_IMPL(a_idle_last, in_ready && out_valid, last, "non-final result pending while idle")

    // A code byte keeps the block busy on the next cycle
    `HTD_ASSERT_NEXT(a_decode_busy, in_valid && in_ready && req_type, !in_ready, "ready right after code byte")

endmodule

bind huffman_tree_decoder_unit htd_checker u_htd_checker (.*);

// ----- tb/tb.sv -----
// Self-checking testbench for huffman_tree_decoder_unit: tree loads, code bytes, symbol limit.
// Depends on htd_pkg and the decoder RTL; a tree walker built into this file predicts each symbol.
module tb;

    localparam int   NODES         = htd_pkg::NODE_COUNT_DEF;
    localparam int   IDX_W         = htd_pkg::IDX_W;
    localparam int   SYM_W         = htd_pkg::SYM_W;
    localparam int   CNT_W         = htd_pkg::CNT_W;
    localparam logic REQ_LOAD      = htd_pkg::REQ_LOAD;
    localparam logic REQ_DECODE    = htd_pkg::REQ_DECODE;
    localparam int   SETTLE_CYCLES = 24;
    localparam int   CYCLE_LIMIT   = 400000;

    // One decoded symbol as seen on the output channel
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             done;
    } sym_res_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic [IDX_W-1:0]  node_index;
    logic [IDX_W-1:0]  parent_index;
    logic [SYM_W-1:0]  node_symbol;
    logic [SYM_W-1:0]  code_byte;
    logic              out_valid;
    logic              out_ready;
    logic [SYM_W-1:0]  symbol;
    logic              last;
    logic              done_res;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CNT_W-1:0]  cfg_data;

    // Tree walker state, mirrors the decoder
    logic              t_has_left [0:NODES-1];
    logic [IDX_W-1:0]  t_left     [0:NODES-1];
    logic [IDX_W-1:0]  t_right    [0:NODES-1];
    logic [SYM_W-1:0]  t_sym      [0:NODES-1];
    logic [IDX_W-1:0]  walk_at;
    logic [CNT_W-1:0]  sym_count;
    logic [CNT_W-1:0]  total_syms;

    sym_res_t          pending_syms [$];
    int                fail_count = 0;
    int                cycle_count = 0;
    int                sink_wait = 0;
    int                sink_hold = 0;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;

    huffman_tree_decoder_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .node_index   (node_index),
        .parent_index (parent_index),
        .node_symbol  (node_symbol),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol       (symbol),
        .last         (last),
        .done_res     (done_res),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Load one node: clear its links, hang it under its parent, restart the walk
    function automatic void attach_node(input logic [IDX_W-1:0] ni, input logic [IDX_W-1:0] pi,
                                        input logic [SYM_W-1:0] ns);
        if (ni < NODES)
        begin
            t_has_left[ni] = 1'b0;
            t_left[ni]     = '0;
            t_right[ni]    = '0;
            t_sym[ni]      = ns;
            if (pi < NODES)
            begin
                if (!t_has_left[pi])
                begin
                    t_has_left[pi] = 1'b1;
                    t_left[pi]     = ni;
                end
                else
                    t_right[pi] = ni;
            end
            walk_at   = '0;
            sym_count = '0;
        end
    endfunction

    // Walk one code byte MSB first and queue the symbols it yields
    function automatic void walk_code(input logic [SYM_W-1:0] cb);
        logic [IDX_W-1:0] cur;
        sym_res_t         outs [0:7];
        int               n;
        n = 0;
        for (int b = 7; b >= 0; b--)
        begin
            // bits are dropped once the symbol limit is reached
            if (sym_count < total_syms)
            begin
                cur = walk_at;
                if (t_has_left[cur])
                    cur = cb[b] ? t_right[cur] : t_left[cur];
                if (!t_has_left[cur])
                begin
                    sym_count++;
                    outs[n].sym  = t_sym[cur];
                    outs[n].last = 1'b0;
                    outs[n].done = (sym_count >= total_syms);
                    n++;
                    walk_at = '0;
                end
                else
                    walk_at = cur;
            end
        end
        if (n > 0)
            outs[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_syms.push_back(outs[k]);
    endfunction

    function automatic void check_field(input string name, input logic [SYM_W-1:0] want,
                                        input logic [SYM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Output side: ready with random gaps and an optional long hold-off
    initial
    begin : sink_drive
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_ready <= 1'b0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare every symbol transaction with the oldest prediction
    always @(posedge clk)
    begin : sym_check
        sym_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            sink_wait = rx_quiet ? 0 : $urandom_range(0, 10);
            if (pending_syms.size() == 0)
            begin
                $display("%0t: symbol transaction, expected none, actual symbol %0h",
                         $time, symbol);
                fail_count++;
            end
            else
            begin
                want = pending_syms.pop_front();
                check_field("symbol", want.sym, symbol);
                check_field("last", {7'd0, want.last}, {7'd0, last});
                check_field("done_res", {7'd0, want.done}, {7'd0, done_res});
            end
        end
    end

    // Offer one input transaction after a random gap and predict it once taken
    task automatic push_item(input logic rq, input logic [IDX_W-1:0] ni,
                             input logic [IDX_W-1:0] pi, input logic [SYM_W-1:0] ns,
                             input logic [SYM_W-1:0] cb);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type     <= rq;
        node_index   <= ni;
        parent_index <= pi;
        node_symbol  <= ns;
        code_byte    <= cb;
        in_valid     <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (rq == REQ_LOAD)
            attach_node(ni, pi, ns);
        else
            walk_code(cb);
    endtask

    task automatic load_node(input logic [IDX_W-1:0] ni, input logic [IDX_W-1:0] pi,
                             input logic [SYM_W-1:0] ns);
        push_item(REQ_LOAD, ni, pi, ns, SYM_W'($urandom_range(0, 255)));
    endtask

    task automatic feed_code(input logic [SYM_W-1:0] cb);
        push_item(REQ_DECODE, IDX_W'($urandom_range(0, 511)), IDX_W'($urandom_range(0, 511)),
                  SYM_W'($urandom_range(0, 255)), cb);
    endtask

    // Stop offering, wait out every predicted symbol, then let the pipe go quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_syms.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write total_symbols; called during the clearing pass after reset or after settle()
    task automatic write_total(input logic [CNT_W-1:0] limit_val);
        @(negedge clk);
        cfg_data  <= limit_val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        total_syms = limit_val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random tree: root 0, leaves split into one or two children at fresh indexes
    task automatic grow_tree(input int leaves);
        logic [IDX_W-1:0] open_nodes [$];
        bit               taken [0:NODES-1];
        logic [IDX_W-1:0] par;
        logic [IDX_W-1:0] kid;
        int               pick;
        int               n_kids;
        for (int k = 0; k < NODES; k++)
            taken[k] = 1'b0;
        taken[0] = 1'b1;
        load_node('0, 9'd511, SYM_W'($urandom_range(0, 255)));
        open_nodes.push_back('0);
        while (open_nodes.size() < leaves)
        begin
            pick = $urandom_range(0, open_nodes.size() - 1);
            par  = open_nodes[pick];
            open_nodes.delete(pick);
            // now and then a node gets a left child only
            n_kids = ($urandom_range(0, 7) == 0) ? 1 : 2;
            repeat (n_kids)
            begin
                kid = IDX_W'($urandom_range(1, NODES - 1));
                while (taken[kid])
                    kid = IDX_W'($urandom_range(1, NODES - 1));
                taken[kid] = 1'b1;
                load_node(kid, par, SYM_W'($urandom_range(0, 255)));
                open_nodes.push_back(kid);
            end
        end
    endtask

    // Small hand-built tree: left/right steps, third child, lone left child, leaf root
    task automatic test_walk_basics();
        write_total(32'hFFFF_FFFF);
        load_node(9'd0, 9'd511, 8'h00);
        load_node(9'd1, 9'd0, 8'hFF);
        load_node(9'd510, 9'd0, 8'hA5);
        feed_code(8'h00);
        feed_code(8'hFF);
        feed_code(8'h96);
        // third child replaces the right link of the root
        load_node(9'd2, 9'd0, 8'h3C);
        feed_code(8'hFF);
        // node 1 gets a left child only; its right step falls back to the root
        load_node(9'd3, 9'd1, 8'h11);
        feed_code(8'h4B);
        // out-of-range node index is dropped
        load_node(9'd511, 9'd0, 8'h77);
        feed_code(8'h80);
        // reloaded root without children is a leaf
        load_node(9'd0, 9'd511, 8'h5A);
        feed_code(8'hC3);
    endtask

    // total_symbols at zero, one and a few: bits past the limit are dropped
    task automatic test_count_limit();
        settle();
        write_total(32'd0);
        feed_code(8'hFF);
        settle();
        write_total(32'd1);
        load_node(9'd0, 9'd511, 8'hE1);
        feed_code(8'h00);
        feed_code(8'hFF);
        settle();
        write_total(32'd3);
        load_node(9'd0, 9'd511, 8'h00);
        feed_code(8'hFF);
        feed_code(8'h12);
    endtask

    // Output held off for a long stretch while code bytes keep coming
    task automatic test_output_stall();
        settle();
        write_total(32'hFFFF_FFFF);
        load_node(9'd0, 9'd511, 8'h42);
        load_node(9'd7, 9'd0, 8'h81);
        load_node(9'd9, 9'd0, 8'h18);
        sink_hold = 300;
        tx_quiet  = 1'b1;
        repeat (12)
            feed_code(SYM_W'($urandom_range(0, 255)));
        tx_quiet = 1'b0;
        settle();
    endtask

    // Phases of random trees, mostly code bytes with some stray loads mixed in
    task automatic test_random_trees();
        logic [CNT_W-1:0] limit_val;
        logic [IDX_W-1:0] pi;
        int               leaves;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                1, 4:    limit_val = $urandom_range(1, 40);
                2:       limit_val = $urandom();
                6:       limit_val = $urandom_range(50, 300);
                default: limit_val = 32'hFFFF_FFFF;
            endcase
            settle();
            write_total(limit_val);
            tx_quiet = (p == 5);
            rx_quiet = (p == 5);
            leaves   = (p == 3) ? 48 : $urandom_range(1, 10);
            grow_tree(leaves);
            for (int i = 0; i < 22; i++)
            begin
                if (i == 11)
                    settle();
                if ($urandom_range(0, 99) < 85)
                    feed_code(SYM_W'($urandom_range(0, 255)));
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       pi = 9'd511;
                        1:       pi = 9'd0;
                        default: pi = IDX_W'($urandom_range(0, 511));
                    endcase
                    load_node(IDX_W'($urandom_range(0, 511)), pi,
                              SYM_W'($urandom_range(0, 255)));
                end
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    initial
    begin : main
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_LOAD;
        node_index   = '0;
        parent_index = '0;
        node_symbol  = '0;
        code_byte    = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        for (int k = 0; k < NODES; k++)
        begin
            t_has_left[k] = 1'b0;
            t_left[k]     = '0;
            t_right[k]    = '0;
            t_sym[k]      = '0;
        end
        walk_at    = '0;
        sym_count  = '0;
        total_syms = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_walk_basics();
        test_count_limit();
        test_output_stall();
        test_random_trees();
        settle();

        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/htd_pkg.sv
rtl/htd_node_store.sv
rtl/htd_count_unit.sv
rtl/huffman_tree_decoder_unit.sv
rtl/htd_checker.sv
tb/tb.sv
